// ===== hdl/lzss_pkg.sv =====
// ---------------------------------------------------------------------------
// lzss_pkg: shared types and microcode for the LZSS stream decoder
// Window geometry, sequencer step codes, control word layout and the
// read-only microprogram that drives the decoder datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package lzss_pkg;

  // Window geometry
  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = 12;
  localparam int MAX_MATCH = 18;
  localparam int MIN_MATCH = 3;
  localparam int CNT_W     = 5;

  localparam logic [WIN_AW-1:0] WP_INIT   = WIN_AW'(WIN_DEPTH - MAX_MATCH);
  localparam logic [WIN_AW-1:0] WIN_LAST  = WIN_AW'(WIN_DEPTH - 1);
  localparam logic [7:0]        FILL_BYTE = 8'h20;
  // first copy count is length - 1, where length = nibble + MIN_MATCH
  localparam logic [CNT_W-1:0]  CNT_BIAS  = CNT_W'(MIN_MATCH - 1);

  // Token decode phase
  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_PAIR  = 2'd2
  } phase_t;

  // Sequencer steps (program addresses)
  typedef enum logic [2:0] {
    S_CLEAR,
    S_FETCH,
    S_FLAG,
    S_LOW,
    S_LIT,
    S_PAIR,
    S_RD,
    S_CPY
  } step_t;

  // Next-step selection
  typedef enum logic [2:0] {
    J_GOTO,   // unconditional jump to target
    J_DISP,   // dispatch on phase and token bit
    J_END,    // fetch next byte, or clear on stream end
    J_CLEAR,  // loop until the window is filled
    J_COPY    // loop to target until the copy count runs out
  } jmp_t;

  // Window write data source
  typedef enum logic [1:0] {
    W_NONE,
    W_FILL,
    W_BYTE,
    W_COPY
  } wsel_t;

  // Output register load source
  typedef enum logic [1:0] {
    O_NONE,
    O_BYTE,
    O_COPY
  } osel_t;

  // Register update operation
  typedef enum logic [2:0] {
    OP_RESET,
    OP_LATCH,
    OP_FLAG,
    OP_LOW,
    OP_LIT,
    OP_PAIR,
    OP_RD,
    OP_CPY
  } op_t;

  typedef struct packed {
    logic  in_rdy;    // take an input transfer in this step
    logic  wait_out;  // step needs a free output register
    logic  ram_re;    // issue a window read
    wsel_t wsel;
    osel_t osel;
    op_t   op;
    jmp_t  jmp;
    step_t tgt;
  } ctl_t;

  // Microprogram ROM
  function automatic ctl_t ucode(input step_t s);
    ctl_t c;
    unique case (s)
      S_CLEAR: c = '{1'b0, 1'b0, 1'b0, W_FILL, O_NONE, OP_RESET, J_CLEAR, S_FETCH};
      S_FETCH: c = '{1'b1, 1'b0, 1'b0, W_NONE, O_NONE, OP_LATCH, J_DISP,  S_FETCH};
      S_FLAG:  c = '{1'b0, 1'b0, 1'b0, W_NONE, O_NONE, OP_FLAG,  J_END,   S_FETCH};
      S_LOW:   c = '{1'b0, 1'b0, 1'b0, W_NONE, O_NONE, OP_LOW,   J_END,   S_FETCH};
      S_LIT:   c = '{1'b0, 1'b1, 1'b0, W_BYTE, O_BYTE, OP_LIT,   J_END,   S_FETCH};
      S_PAIR:  c = '{1'b0, 1'b0, 1'b0, W_NONE, O_NONE, OP_PAIR,  J_GOTO,  S_RD};
      S_RD:    c = '{1'b0, 1'b0, 1'b1, W_NONE, O_NONE, OP_RD,    J_GOTO,  S_CPY};
      S_CPY:   c = '{1'b0, 1'b1, 1'b0, W_COPY, O_COPY, OP_CPY,   J_COPY,  S_RD};
      default: c = '{1'b0, 1'b0, 1'b0, W_NONE, O_NONE, OP_RESET, J_GOTO,  S_CLEAR};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lzss_ram.sv =====
// ---------------------------------------------------------------------------
// lzss_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lzss_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// lzss_stream_decoder: LZSS decompressor, 4096-byte window
// Microcoded sequencer over a window RAM: flag bytes, literals and
// position/length pairs are decoded one compressed byte per transfer.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  in      | input     | in_valid / in_ready  | in_byte, in_stream_end
//  out     | output    | out_valid / out_ready| out_byte, out_run_last
//
//  Flag byte, first pair byte and literal: the fetch step, then one decode step.
//  Pair: fetch and pair steps, then per copied byte a window read step followed
//  by a write step on the single RAM port pair.
//  After reset and after every item marked stream end, a fill pass over all
//  4096 window entries writes spaces; in_ready stays low during it.
//  out_ready low holds the sequencer at its output step; input is taken
//  only in the fetch step.
`default_nettype none

module lzss_stream_decoder
  import lzss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_stream_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_byte,
  output logic            out_run_last
);

  // sequencer
  step_t upc_r, upc_nxt;
  ctl_t  ctl;
  logic  go, out_free;
  step_t end_step;

  // control registers
  logic [WIN_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [8:0]        flags_r, flags_nxt;
  phase_t            phase_r, phase_nxt;

  // payload registers
  logic [7:0]        byte_r, byte_nxt;
  logic              end_r, end_nxt;
  logic [7:0]        pend_r, pend_nxt;
  logic [WIN_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;

  // token bookkeeping
  logic [8:0] flags_sh;
  phase_t     phase_done;

  // window RAM
  logic              ram_we, ram_re;
  logic [WIN_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WIN_DEPTH)
  ) u_win (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // control word and stall
  assign ctl      = ucode(upc_r);
  assign in_ready = ctl.in_rdy;
  assign out_free = !out_valid_r || out_ready;
  assign go       = !((ctl.in_rdy && !in_valid) || (ctl.wait_out && !out_free));
  assign end_step = end_r ? S_CLEAR : S_FETCH;

  assign flags_sh   = {1'b0, flags_r[8:1]};
  assign phase_done = (flags_sh > 9'd1) ? PH_TOKEN : PH_FLAG;

  // window write port
  assign ram_we    = go && (ctl.wsel != W_NONE);
  assign ram_re    = go && ctl.ram_re;
  assign ram_waddr = (ctl.wsel == W_FILL) ? clr_cnt_r : wp_r;
  always_comb begin
    unique case (ctl.wsel)
      W_FILL:  ram_wdata = FILL_BYTE;
      W_BYTE:  ram_wdata = byte_r;
      W_COPY:  ram_wdata = ram_rdata;
      default: ram_wdata = FILL_BYTE;
    endcase
  end

  // next step
  always_comb begin
    upc_nxt = upc_r;
    if (go) begin
      unique case (ctl.jmp)
        J_GOTO: upc_nxt = ctl.tgt;
        J_DISP: begin
          unique case (phase_r)
            PH_TOKEN: upc_nxt = flags_r[0] ? S_LIT : S_LOW;
            PH_PAIR:  upc_nxt = S_PAIR;
            default:  upc_nxt = S_FLAG;
          endcase
        end
        J_END:   upc_nxt = end_step;
        J_CLEAR: upc_nxt = (clr_cnt_r == WIN_LAST) ? ctl.tgt : S_CLEAR;
        J_COPY:  upc_nxt = (cnt_r == '0) ? end_step : ctl.tgt;
        default: upc_nxt = S_CLEAR;
      endcase
    end
  end

  // datapath register updates
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    wp_nxt      = wp_r;
    flags_nxt   = flags_r;
    phase_nxt   = phase_r;
    byte_nxt    = byte_r;
    end_nxt     = end_r;
    pend_nxt    = pend_r;
    rd_ptr_nxt  = rd_ptr_r;
    cnt_nxt     = cnt_r;
    if (go) begin
      unique case (ctl.op)
        OP_RESET: begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
          wp_nxt      = WP_INIT;
          flags_nxt   = '0;
          phase_nxt   = PH_FLAG;
          pend_nxt    = '0;
        end
        OP_LATCH: begin
          byte_nxt = in_byte;
          end_nxt  = in_stream_end;
        end
        OP_FLAG: begin
          flags_nxt = {1'b1, byte_r};
          phase_nxt = PH_TOKEN;
        end
        OP_LOW: begin
          pend_nxt  = byte_r;
          phase_nxt = PH_PAIR;
        end
        OP_LIT: begin
          wp_nxt    = wp_r + 1'b1;
          flags_nxt = flags_sh;
          phase_nxt = phase_done;
        end
        OP_PAIR: begin
          rd_ptr_nxt = {byte_r[7:4], pend_r};
          cnt_nxt    = {1'b0, byte_r[3:0]} + CNT_BIAS;
          flags_nxt  = flags_sh;
          phase_nxt  = phase_done;
        end
        OP_RD: begin
          rd_ptr_nxt = rd_ptr_r + 1'b1;
        end
        OP_CPY: begin
          wp_nxt  = wp_r + 1'b1;
          cnt_nxt = cnt_r - 1'b1;
        end
        default: begin
          clr_cnt_nxt = clr_cnt_r;
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    obyte_nxt     = obyte_r;
    olast_nxt     = olast_r;
    if (go && ctl.osel != O_NONE) begin
      out_valid_nxt = 1'b1;
      obyte_nxt     = (ctl.osel == O_BYTE) ? byte_r : ram_rdata;
      olast_nxt     = (ctl.osel == O_BYTE) || (cnt_r == '0);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      wp_r        <= WP_INIT;
      flags_r     <= '0;
      phase_r     <= PH_FLAG;
    end else begin
      upc_r       <= upc_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      wp_r        <= wp_nxt;
      flags_r     <= flags_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    end_r    <= end_nxt;
    pend_r   <= pend_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    cnt_r    <= cnt_nxt;
    obyte_r  <= obyte_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = obyte_r;
  assign out_run_last = olast_r;

endmodule

`default_nettype wire

// ===== hdl/lzss_checker.sv =====
// ---------------------------------------------------------------------------
// lzss_checker: port-level checks for the LZSS stream decoder
// Watches the top-level ports only; attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module lzss_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_stream_end,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_run_last
);

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_run_last))
    else $error("result changed while stalled");

  // window fill pass follows reset: no input taken
  a_fill_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("decoder active right after reset");

  // in_ready is low right after every input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // stream end starts the fill pass, so input stays blocked after it
  a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_stream_end |=> ##1 !in_ready)
    else $error("input taken right after stream end");

endmodule

bind lzss_stream_decoder lzss_checker u_lzss_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench for lzss_stream_decoder
// Drives compressed bytes, first from a directed table and then as random
// streams that follow the token structure with some noise, stream ends and
// truncated tokens, under random idling on both sides. Typed rows are checked
// inline, all other bytes against a behavioral decoder with its own 4096-byte window.
// ---------------------------------------------------------------------------
module tb;
  import lzss_pkg::*;

  localparam int RANDOM_ITEMS  = 460;
  localparam int DIRECTED_ROWS = 20;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // One directed transfer; typed rows carry their expected bytes inline
  typedef struct packed {
    logic [7:0] data;
    logic       stream_end;
    logic       typed;
    logic [4:0] count;
    logic [7:0] value;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_stream_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_run_last;

  // Typed expectation of the item on the input port
  logic       row_typed;
  logic [4:0] row_count;
  logic [7:0] row_value;

  // Behavioral decoder state
  logic [7:0]        win_m [WIN_DEPTH];
  logic [WIN_AW-1:0] wp_m;
  logic [8:0]        flags_m;
  phase_t            phase_m;
  logic [7:0]        low_m;

  out_beat_t decoded_now[$];
  out_beat_t expected_bytes[$];
  out_beat_t want;
  stim_row_t directed_rows [DIRECTED_ROWS];

  int   fail_count = 0;
  int   beats_seen = 0;
  logic calm       = 1'b0;
  logic held       = 1'b0;

  lzss_stream_decoder DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_stream_end(in_stream_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  always #10 clk = ~clk;

  // Decoder state back to its power-up values, window filled with spaces
  function automatic void window_reset();
    for (int i = 0; i < WIN_DEPTH; i++) win_m[i] = FILL_BYTE;
    wp_m    = WP_INIT;
    flags_m = '0;
    phase_m = PH_FLAG;
    low_m   = '0;
  endfunction

  function automatic void emit_and_store(input logic [7:0] c);
    decoded_now.push_back('{data: c, last: 1'b0});
    win_m[wp_m] = c;
    wp_m        = wp_m + 1'b1;
  endfunction

  // Decode one compressed byte into decoded_now
  function automatic void lzss_decode_byte(input logic [7:0] b, input logic e);
    logic [WIN_AW-1:0] pos;
    int                len;
    out_beat_t         tail;
    decoded_now.delete();
    case (phase_m)
      PH_TOKEN: begin
        if (flags_m[0]) begin
          emit_and_store(b);
          flags_m = flags_m >> 1;
          phase_m = (flags_m > 9'd1) ? PH_TOKEN : PH_FLAG;
        end else begin
          low_m   = b;
          phase_m = PH_PAIR;
        end
      end
      PH_PAIR: begin
        pos = {b[7:4], low_m};
        len = int'(b[3:0]) + MIN_MATCH;
        // copy byte by byte so an overlapping source repeats fresh bytes
        for (int k = 0; k < len; k++) emit_and_store(win_m[pos + WIN_AW'(k)]);
        flags_m = flags_m >> 1;
        phase_m = (flags_m > 9'd1) ? PH_TOKEN : PH_FLAG;
      end
      default: begin
        flags_m = {1'b1, b};
        phase_m = PH_TOKEN;
      end
    endcase
    if (decoded_now.size() > 0) begin
      tail      = decoded_now.pop_back();
      tail.last = 1'b1;
      decoded_now.push_back(tail);
    end
    if (e) window_reset();
  endfunction

  // Offer one byte and hold it until the transfer; returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic e, input logic t,
                           input logic [4:0] cnt, input logic [7:0] v);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    in_stream_end <= e;
    row_typed     <= t;
    row_count     <= cnt;
    row_value     <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        lzss_decode_byte(in_byte, in_stream_end);
        if (row_typed) begin
          for (int i = 0; i < int'(row_count); i++)
            expected_bytes.push_back('{data: row_value, last: i == int'(row_count) - 1});
        end else begin
          foreach (decoded_now[i]) expected_bytes.push_back(decoded_now[i]);
        end
      end
      if (out_valid && out_ready) begin
        beats_seen++;
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected no transfer, got %02h", out_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            fail_count++;
          end
          if (out_run_last !== want.last) begin
            $error("out_run_last: expected %0b, got %0b", want.last, out_run_last);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: random idling, one long hold so the decoder backs up
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && beats_seen >= 120) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 27);
    end
  end

  // Stimulus
  initial begin
    logic [7:0]        b;
    logic              e;
    logic [WIN_AW-1:0] pos;
    logic [3:0]        pos_hi;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte       = '0;
    in_stream_end = 1'b0;
    row_typed     = 1'b0;
    row_count     = '0;
    row_value     = '0;
    pos_hi        = '0;
    window_reset();

    directed_rows = '{
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},  // flag: eight pairs
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'h0F, 1'b0, 1'b1, 5'd18, 8'h20},  // position 0, longest copy
      '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'hF0, 1'b0, 1'b1, 5'd3,  8'h20},  // last position, wraps
      '{8'h12, 1'b1, 1'b1, 5'd0,  8'h00},  // stream ends on first pair byte
      '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00},  // flag: eight literals
      '{8'h00, 1'b0, 1'b1, 5'd1,  8'h00},
      '{8'hFF, 1'b0, 1'b1, 5'd1,  8'hFF},
      '{8'h55, 1'b0, 1'b1, 5'd1,  8'h55},
      '{8'hAA, 1'b0, 1'b1, 5'd1,  8'hAA},
      '{8'h01, 1'b0, 1'b1, 5'd1,  8'h01},
      '{8'h80, 1'b0, 1'b1, 5'd1,  8'h80},
      '{8'h7F, 1'b0, 1'b1, 5'd1,  8'h7F},
      '{8'h41, 1'b0, 1'b1, 5'd1,  8'h41},
      '{8'h02, 1'b0, 1'b1, 5'd0,  8'h00},  // flag: pair, then literal
      '{8'hF4, 1'b0, 1'b0, 5'd0,  8'h00},
      '{8'hFF, 1'b0, 1'b0, 5'd0,  8'h00},  // overlapping copy of fresh bytes
      '{8'h33, 1'b1, 1'b1, 5'd1,  8'h33},  // literal with stream end
      '{8'hA5, 1'b1, 1'b1, 5'd0,  8'h00}   // stream ends on flag byte
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].stream_end,
                directed_rows[i].typed, directed_rows[i].count, directed_rows[i].value);

    // Random streams: content follows the token structure, with some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 150 && n < 230);
      case (phase_m)
        PH_TOKEN: begin
          if (flags_m[0]) begin
            b = 8'($urandom);
          end else begin
            // mostly recent history, sometimes anywhere in the window
            if ($urandom_range(9) < 7) pos = wp_m - WIN_AW'($urandom_range(1, 48));
            else pos = WIN_AW'($urandom);
            b      = pos[7:0];
            pos_hi = pos[11:8];
          end
        end
        PH_PAIR: b = {pos_hi, 4'($urandom_range(15))};
        default: begin
          case ($urandom_range(9))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
          endcase
        end
      endcase
      if ($urandom_range(19) == 0) b = 8'($urandom);
      e = ($urandom_range(69) == 0);
      send_byte(b, e, 1'b0, '0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then allow for a longest copy before closing
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
